@@ sv/asw_pkg.sv @@
// ----------------------------------------------------------------------------
// Annealing swap ordering package
// Shared constants, codes, state type and the -ln table function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asw_pkg;

  localparam int unsigned MaxItemsDef = 256;
  localparam int unsigned DistBitsDef = 16;
  localparam int unsigned LogDepthDef = 1024;

  localparam int unsigned RomBits     = 20;
  localparam int unsigned ChangeBits  = 19;
  localparam int unsigned EnergyBits  = 25;
  localparam int unsigned DeltaSat    = 262140;
  localparam int unsigned EnergySat   = 16776960;
  localparam int unsigned Ln2Q16      = 45426;

  localparam logic [8:0]  ItemCountRst = 9'd256;
  localparam logic [31:0] StartTempRst = 32'd6553600;
  localparam logic [15:0] CoolingRst   = 16'd65000;

  typedef logic [2:0] mode_t;
  localparam mode_t ModeLoadDist  = 3'd0;
  localparam mode_t ModeLoadOrder = 3'd1;
  localparam mode_t ModeStart     = 3'd2;
  localparam mode_t ModeStep      = 3'd3;
  localparam mode_t ModeReadBest  = 3'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgItemCount = 2'd0;
  localparam cfg_idx_t CfgStartTemp = 2'd1;
  localparam cfg_idx_t CfgCooling   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDB,
    S_ORD,
    S_DIST,
    S_CALC,
    S_DECIDE,
    S_SWAP,
    S_COPY,
    S_FINISH
  } state_e;

  function automatic logic [63:0] log2_q16(input logic [63:0] m);
    logic [63:0] ip;
    logic [63:0] y;
    logic [63:0] frac;
    ip = '0;
    for (int s = 0; s < 63; s++) begin
      if ((m >> (s + 1)) != 64'd0) ip = 64'(s + 1);
    end
    y = (m << 16) >> ip;
    frac = '0;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 16;
      if (y >= 64'd131072) begin
        y = y >> 1;
        frac[b] = 1'b1;
      end
    end
    return (ip << 16) | frac;
  endfunction

  function automatic logic [RomBits-1:0] neg_ln_q16(input int unsigned k,
                                                    input int unsigned depth);
    logic [63:0] diff;
    logic [63:0] prod;
    diff = log2_q16(64'(depth)) - log2_q16(64'(k) + 64'd1);
    prod = (diff * 64'(Ln2Q16)) >> 16;
    return prod[RomBits-1:0];
  endfunction

endpackage

@@ sv/annealing_swap_ordering.sv @@
// ----------------------------------------------------------------------------
// Annealing swap ordering
// Distance matrix, current and best order in block memories; swap steps with
// exact path-length change, Metropolis test and geometric cooling.
// ----------------------------------------------------------------------------
// Usage: load distances (mode 0) and the order (mode 1), send a start word
// (mode 2), then step words (mode 3) carrying two positions and a draw; mode 4
// reads the best order. Every input word yields one output word.
// Input and output words move on valid/stall channels; configuration writes
// use a valid/ready port that is always ready and must come while idle.
// Per word, a step makes six order reads and up to eight distance reads through
// one read port per memory, and when it finds a new best the order copy
// sweeps the best store; start runs the same copy.
// One word is in work at a time; a finished word waits in the output
// register while the next input word is taken. A stalled receiver holds the
// output word and stops the block at its final cycle.
// Reset clears energies, loads the register defaults and the temperature;
// the memories hold nothing defined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module annealing_swap_ordering #(
  parameter int unsigned MAX_ITEMS       = asw_pkg::MaxItemsDef,
  parameter int unsigned DIST_BITS       = asw_pkg::DistBitsDef,
  parameter int unsigned LOG_TABLE_DEPTH = asw_pkg::LogDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  col_i,
  input  logic [15:0] value_i,
  input  logic [15:0] draw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        improved_o,
  output logic signed [18:0] energy_change_o,
  output logic signed [24:0] relative_energy_o,
  output logic [7:0]  best_entry_o
);

  localparam int unsigned AW  = $clog2(MAX_ITEMS);
  localparam int unsigned PW  = (AW > 9) ? AW : 9;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned DAW = $clog2(MAX_ITEMS * MAX_ITEMS);
  localparam int unsigned SW  = DIST_BITS + 2;
  localparam int unsigned DW  = (DIST_BITS + 3 > 20) ? DIST_BITS + 3 : 20;
  localparam int unsigned RB  = asw_pkg::RomBits;
  localparam int unsigned CB  = asw_pkg::ChangeBits;
  localparam int unsigned EB  = asw_pkg::EnergyBits;
  localparam int unsigned MB  = 32 + RB;

  localparam logic [NW-1:0]        MaxN  = NW'(MAX_ITEMS);
  localparam logic [AW:0]          CpEnd = (AW + 1)'(MAX_ITEMS);
  localparam logic signed [DW-1:0] DPos  = DW'(asw_pkg::DeltaSat);
  localparam logic signed [DW-1:0] DNeg  = -DPos;
  localparam logic signed [EB:0]   EPos  = (EB + 1)'(asw_pkg::EnergySat);
  localparam logic signed [EB:0]   ENeg  = -EPos;

  // memories
  logic [DIST_BITS-1:0] dist_mem [MAX_ITEMS * MAX_ITEMS];
  logic [7:0]           cur_mem  [MAX_ITEMS];
  logic [7:0]           best_mem [MAX_ITEMS];

  logic                 dist_we;
  logic [DAW-1:0]       dist_wa, dist_ra;
  logic [DIST_BITS-1:0] dist_wd, dist_rd;
  logic                 cur_we;
  logic [AW-1:0]        cur_wa, cur_ra;
  logic [7:0]           cur_wd, cur_rd;
  logic                 best_we;
  logic [AW-1:0]        best_wa, best_ra;
  logic [7:0]           best_wd, best_rd;

  // control and configuration
  asw_pkg::state_e state_q, state_d;
  logic [3:0]          sc_q;
  logic [AW:0]         cp_q;
  logic                out_valid_q;
  logic signed [EB-1:0] energy_q, ebest_q;
  logic [31:0]         temp_q;
  logic [8:0]          item_count_q;
  logic [31:0]         start_temp_q;
  logic [15:0]         cooling_q;

  // payload
  logic [7:0]          row_q, col_q;
  logic [15:0]         draw_q;
  logic                swap_ok_q;
  logic [7:0]          ord_q [6];
  logic [SW-1:0]       sa_q, sb_q;
  logic                use_q, aft_q;
  logic signed [CB-1:0] change_q;
  logic [MB-1:0]       prod_q;
  logic [31:0]         coolt_q;
  logic                imp_q;
  logic                res_acc_q, res_imp_q;
  logic signed [CB-1:0] res_change_q;
  logic [7:0]          res_best_q;
  logic                out_acc_q, out_imp_q;
  logic signed [CB-1:0] out_change_q;
  logic signed [EB-1:0] out_energy_q;
  logic [7:0]          out_best_q;

  // combinational
  logic                in_acc, out_free;
  logic [NW-1:0]       n_w;
  logic                swap_ok_in;
  logic [PW-1:0]       rowp, colp;
  logic [PW-1:0]       pos_w [6];
  logic [AW-1:0]       slot_addr [6];
  logic [7:0]          swp_w [6];
  logic [3:0]          ev_w;
  logic [1:0]          e_sel;
  logic                aft_w, use_w;
  logic [7:0]          ea, eb, bva, bvb, ava, avb;
  logic                evs;
  logic signed [DW-1:0] diff_w;
  logic signed [CB-1:0] change_w;
  logic signed [EB:0]  en_sum;
  logic signed [EB-1:0] en_new;
  logic                acc_w, imp_w;
  logic [RB-1:0]       rom_val;
  logic [15:0]         rom_draw;
  logic [47:0]         cool_prod;

  function automatic logic in_items(input logic [7:0] x);
    return NW'(x) < MaxN;
  endfunction

  function automatic logic [DAW-1:0] daddr(input logic [7:0] a, input logic [7:0] b);
    return DAW'(a) * DAW'(MAX_ITEMS) + DAW'(b);
  endfunction

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != asw_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign n_w = (NW'(item_count_q) > MaxN) ? MaxN : NW'(item_count_q);
  assign swap_ok_in = (NW'(row_i) < n_w) && (NW'(col_i) < n_w);

  // window positions around both swap positions
  assign rowp = PW'(row_q);
  assign colp = PW'(col_q);

  always_comb begin
    pos_w[0] = (row_q == 8'd0) ? '0 : rowp - PW'(1);
    pos_w[1] = rowp;
    pos_w[2] = rowp + PW'(1);
    pos_w[3] = (col_q == 8'd0) ? '0 : colp - PW'(1);
    pos_w[4] = colp;
    pos_w[5] = colp + PW'(1);
    for (int s = 0; s < 6; s++) begin
      slot_addr[s] = (NW'(pos_w[s]) < MaxN) ? AW'(pos_w[s]) : '0;
      if (pos_w[s] == rowp) begin
        swp_w[s] = ord_q[4];
      end else if (pos_w[s] == colp) begin
        swp_w[s] = ord_q[1];
      end else begin
        swp_w[s] = ord_q[s];
      end
    end
  end

  // edges: left of row, right of row, left of col, right of col (dups dropped)
  always_comb begin
    ev_w[0] = (row_q != 8'd0);
    ev_w[1] = (NW'(row_q) + NW'(1)) < n_w;
    ev_w[2] = (col_q != 8'd0) && (col_q != row_q) && (colp != rowp + PW'(1));
    ev_w[3] = ((NW'(col_q) + NW'(1)) < n_w) && (col_q != row_q)
              && (colp + PW'(1) != rowp);
  end

  assign e_sel = sc_q[2:1];
  assign aft_w = sc_q[0];

  always_comb begin
    case (e_sel)
      2'd0: begin
        bva = ord_q[0]; bvb = ord_q[1]; ava = swp_w[0]; avb = swp_w[1]; evs = ev_w[0];
      end
      2'd1: begin
        bva = ord_q[1]; bvb = ord_q[2]; ava = swp_w[1]; avb = swp_w[2]; evs = ev_w[1];
      end
      2'd2: begin
        bva = ord_q[3]; bvb = ord_q[4]; ava = swp_w[3]; avb = swp_w[4]; evs = ev_w[2];
      end
      default: begin
        bva = ord_q[4]; bvb = ord_q[5]; ava = swp_w[4]; avb = swp_w[5]; evs = ev_w[3];
      end
    endcase
    ea    = aft_w ? ava : bva;
    eb    = aft_w ? avb : bvb;
    use_w = evs && in_items(ea) && in_items(eb) && (sc_q < 4'd8);
  end

  // change, acceptance, energy
  always_comb begin
    diff_w = $signed(DW'(sa_q)) - $signed(DW'(sb_q));
    if (diff_w > DPos) begin
      change_w = CB'(DPos);
    end else if (diff_w < DNeg) begin
      change_w = CB'(DNeg);
    end else begin
      change_w = CB'(diff_w);
    end
    acc_w  = swap_ok_q && ((change_q <= 0) || (prod_q >= MB'({change_q[17:0], 24'd0})));
    en_sum = (EB + 1)'(energy_q) + (EB + 1)'(change_q);
    if (en_sum > EPos) begin
      en_new = EB'(EPos);
    end else if (en_sum < ENeg) begin
      en_new = EB'(ENeg);
    end else begin
      en_new = EB'(en_sum);
    end
    imp_w = acc_w && (en_new < ebest_q);
  end

  assign cool_prod = 48'(temp_q) * 48'(cooling_q);
  assign rom_draw  = (state_q == asw_pkg::S_IDLE) ? draw_i : draw_q;

  asw_neg_ln_rom #(
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_rom (
    .clk_i (clk_i),
    .draw_i(rom_draw),
    .val_o (rom_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      asw_pkg::S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            asw_pkg::ModeStart:    state_d = asw_pkg::S_COPY;
            asw_pkg::ModeStep:     state_d = swap_ok_in ? asw_pkg::S_ORD : asw_pkg::S_CALC;
            asw_pkg::ModeReadBest: state_d = asw_pkg::S_RDB;
            default:               state_d = asw_pkg::S_FINISH;
          endcase
        end
      end
      asw_pkg::S_RDB:  state_d = asw_pkg::S_FINISH;
      asw_pkg::S_ORD:  if (sc_q == 4'd6) state_d = asw_pkg::S_DIST;
      asw_pkg::S_DIST: if (sc_q == 4'd8) state_d = asw_pkg::S_CALC;
      asw_pkg::S_CALC: state_d = asw_pkg::S_DECIDE;
      asw_pkg::S_DECIDE: begin
        if (acc_w && (row_q != col_q)) begin
          state_d = asw_pkg::S_SWAP;
        end else if (imp_w) begin
          state_d = asw_pkg::S_COPY;
        end else begin
          state_d = asw_pkg::S_FINISH;
        end
      end
      asw_pkg::S_SWAP: begin
        if (sc_q == 4'd1) state_d = imp_q ? asw_pkg::S_COPY : asw_pkg::S_FINISH;
      end
      asw_pkg::S_COPY:   if (cp_q == CpEnd) state_d = asw_pkg::S_FINISH;
      asw_pkg::S_FINISH: if (out_free) state_d = asw_pkg::S_IDLE;
      default:           state_d = asw_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    dist_we = 1'b0;
    dist_wa = daddr(row_i, col_i);
    dist_wd = DIST_BITS'(value_i);
    dist_ra = '0;
    cur_we  = 1'b0;
    cur_wa  = AW'(row_i);
    cur_wd  = value_i[7:0];
    cur_ra  = '0;
    best_we = 1'b0;
    best_wa = AW'(cp_q - (AW + 1)'(1));
    best_wd = cur_rd;
    best_ra = AW'(row_q);
    case (state_q)
      asw_pkg::S_IDLE: begin
        dist_we = in_acc && (mode_i == asw_pkg::ModeLoadDist)
                  && in_items(row_i) && in_items(col_i);
        cur_we  = in_acc && (mode_i == asw_pkg::ModeLoadOrder) && in_items(row_i);
        best_ra = in_items(row_i) ? AW'(row_i) : '0;
      end
      asw_pkg::S_ORD: begin
        if (sc_q < 4'd6) cur_ra = slot_addr[sc_q[2:0]];
      end
      asw_pkg::S_DIST: begin
        if (use_w) dist_ra = daddr(ea, eb);
      end
      asw_pkg::S_SWAP: begin
        cur_we = 1'b1;
        if (sc_q == 4'd0) begin
          cur_wa = slot_addr[1];
          cur_wd = ord_q[4];
        end else begin
          cur_wa = slot_addr[4];
          cur_wd = ord_q[1];
        end
      end
      asw_pkg::S_COPY: begin
        if (cp_q < CpEnd) cur_ra = AW'(cp_q);
        best_we = (cp_q != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    best_rd <= best_mem[best_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= asw_pkg::S_IDLE;
      sc_q         <= '0;
      cp_q         <= '0;
      out_valid_q  <= 1'b0;
      energy_q     <= '0;
      ebest_q      <= '0;
      temp_q       <= asw_pkg::StartTempRst;
      item_count_q <= asw_pkg::ItemCountRst;
      start_temp_q <= asw_pkg::StartTempRst;
      cooling_q    <= asw_pkg::CoolingRst;
    end else begin
      state_q <= state_d;
      sc_q    <= (state_d == state_q) ? sc_q + 4'd1 : 4'd0;
      cp_q    <= (state_q == asw_pkg::S_COPY && state_d == asw_pkg::S_COPY)
                 ? cp_q + (AW + 1)'(1) : '0;
      if (state_q == asw_pkg::S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == asw_pkg::S_IDLE && in_acc && mode_i == asw_pkg::ModeStart) begin
        energy_q <= '0;
        ebest_q  <= '0;
        temp_q   <= start_temp_q;
      end
      if (state_q == asw_pkg::S_DECIDE) begin
        if (acc_w) energy_q <= en_new;
        if (imp_w) ebest_q <= en_new;
        temp_q <= coolt_q;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          asw_pkg::CfgItemCount: item_count_q <= cfg_data_i[8:0];
          asw_pkg::CfgStartTemp: start_temp_q <= cfg_data_i;
          asw_pkg::CfgCooling:   cooling_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      asw_pkg::S_IDLE: begin
        if (in_acc) begin
          row_q        <= row_i;
          col_q        <= col_i;
          draw_q       <= draw_i;
          swap_ok_q    <= (mode_i == asw_pkg::ModeStep) && swap_ok_in;
          sa_q         <= '0;
          sb_q         <= '0;
          imp_q        <= 1'b0;
          res_acc_q    <= 1'b0;
          res_imp_q    <= 1'b0;
          res_change_q <= '0;
          res_best_q   <= '0;
        end
      end
      asw_pkg::S_RDB: begin
        res_best_q <= in_items(row_q) ? best_rd : 8'd0;
      end
      asw_pkg::S_ORD: begin
        if (sc_q != 4'd0) ord_q[sc_q[2:0] - 3'd1] <= cur_rd;
      end
      asw_pkg::S_DIST: begin
        use_q <= use_w;
        aft_q <= aft_w;
        if (sc_q != 4'd0 && use_q) begin
          if (aft_q) begin
            sa_q <= sa_q + SW'(dist_rd);
          end else begin
            sb_q <= sb_q + SW'(dist_rd);
          end
        end
      end
      asw_pkg::S_CALC: begin
        change_q <= change_w;
        prod_q   <= MB'(temp_q) * MB'(rom_val);
        coolt_q  <= cool_prod[47:16];
      end
      asw_pkg::S_DECIDE: begin
        res_acc_q    <= acc_w;
        res_imp_q    <= imp_w;
        res_change_q <= change_q;
        imp_q        <= imp_w;
      end
      asw_pkg::S_FINISH: begin
        if (out_free) begin
          out_acc_q    <= res_acc_q;
          out_imp_q    <= res_imp_q;
          out_change_q <= res_change_q;
          out_energy_q <= energy_q;
          out_best_q   <= res_best_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign improved_o        = out_imp_q;
  assign energy_change_o   = out_change_q;
  assign relative_energy_o = out_energy_q;
  assign best_entry_o      = out_best_q;

endmodule

@@ sv/asw_neg_ln_rom.sv @@
// ----------------------------------------------------------------------------
// Negative log table
// Maps a Q0.16 draw to -ln of its bin in Q4.16, registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asw_neg_ln_rom #(
  parameter int unsigned LOG_TABLE_DEPTH = asw_pkg::LogDepthDef
) (
  input  logic                         clk_i,
  input  logic [15:0]                  draw_i,
  output logic [asw_pkg::RomBits-1:0]  val_o
);

  localparam int unsigned KW = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned PW = 16 + KW + 1;

  logic [asw_pkg::RomBits-1:0] tbl [LOG_TABLE_DEPTH];
  logic [PW-1:0]               bin_prod;
  logic [KW-1:0]               bin;
  logic [asw_pkg::RomBits-1:0] val_q;

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tbl
    localparam logic [asw_pkg::RomBits-1:0] V = asw_pkg::neg_ln_q16(g, LOG_TABLE_DEPTH);
    assign tbl[g] = V;
  end

  assign bin_prod = PW'(draw_i) * PW'(LOG_TABLE_DEPTH);
  assign bin      = bin_prod[16 +: KW];

  always_ff @(posedge clk_i) begin
    val_q <= tbl[bin];
  end

  assign val_o = val_q;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Annealing swap ordering testbench
// Preloads a distance matrix over a small pool of items and a full order, then
// walks a directed table and random phases under several register settings,
// with bursty input, random and long output stalls. Every output word is
// checked field by field against an in-bench model of the swap annealer or,
// for typed table rows, against the expected word given in the table.
`timescale 1ns / 1ps

module tb;

  localparam asw_pkg::mode_t ModeUnusedLo = 3'd5;
  localparam asw_pkg::mode_t ModeUnusedHi = 3'd7;
  localparam int    PoolSize     = 6;
  localparam int    IdleLimit    = 20000;
  localparam int    LongHold     = 400;
  localparam int    PhaseWords   = 33;

  typedef struct packed {
    asw_pkg::mode_t mode;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] value;
    logic [15:0] draw;
  } in_word_t;

  typedef struct packed {
    logic              acc;
    logic              imp;
    logic signed [18:0] chg;
    logic signed [24:0] energy;
    logic [7:0]        best;
  } out_word_t;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t res;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  asw_pkg::cfg_idx_t cfg_index_i = asw_pkg::CfgItemCount;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = asw_pkg::ModeLoadDist;
  logic [7:0]  row_i = '0;
  logic [7:0]  col_i = '0;
  logic [15:0] value_i = '0;
  logic [15:0] draw_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic        improved_o;
  logic signed [18:0] energy_change_o;
  logic signed [24:0] relative_energy_o;
  logic [7:0]  best_entry_o;

  annealing_swap_ordering DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [15:0] dist_mem [0:65535];
  logic [7:0]  cur_ord [0:255];
  logic [7:0]  best_ord [0:255];
  longint      e_now, e_best;
  logic [31:0] temp_q;
  logic [8:0]  item_cnt = asw_pkg::ItemCountRst;
  logic [31:0] start_temp = asw_pkg::StartTempRst;
  logic [15:0] cool = asw_pkg::CoolingRst;

  out_word_t   pending_q [$];
  logic [7:0]  pool [PoolSize] = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd3, 8'd64};
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_pct = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  int          hold_cnt = 0;
  bit          hold_req = 0;
  table_row_t  dir_tab [16];

  function automatic longint unsigned log2_fix(longint unsigned m);
    longint unsigned ip, y, frac;
    ip = 0;
    frac = 0;
    while ((m >> (ip + 1)) != 0) ip++;
    y = (m << 16) >> ip;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 16;
      if (y >= 131072) begin
        y = y >> 1;
        frac = frac | (longint'(1) << b);
      end
    end
    return (ip << 16) | frac;
  endfunction

  function automatic longint unsigned neg_ln(logic [15:0] draw);
    longint unsigned k, d;
    k = (longint'(draw) * asw_pkg::LogDepthDef) >> 16;
    d = log2_fix(asw_pkg::LogDepthDef) - log2_fix(k + 1);
    return (d * asw_pkg::Ln2Q16) >> 16;
  endfunction

  function automatic longint edge_len(int e, int n);
    if (e < 0 || e > n - 2) return 0;
    return dist_mem[{cur_ord[e], cur_ord[e + 1]}];
  endfunction

  function automatic longint near_len(int i, int j, int n);
    int lst [4];
    longint s;
    bit dup;
    lst = '{i - 1, i, j - 1, j};
    s = 0;
    for (int a = 0; a < 4; a++) begin
      dup = 0;
      for (int b = 0; b < a; b++) if (lst[b] == lst[a]) dup = 1;
      if (!dup) s += edge_len(lst[a], n);
    end
    return s;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic out_word_t anneal_word(in_word_t w);
    out_word_t r;
    int n;
    longint base, chg;
    logic [7:0] t;
    r = '0;
    chg = 0;
    n = (item_cnt > asw_pkg::MaxItemsDef) ? int'(asw_pkg::MaxItemsDef) : int'(item_cnt);
    case (w.mode)
      asw_pkg::ModeLoadDist: dist_mem[{w.row, w.col}] = w.value;
      asw_pkg::ModeLoadOrder: cur_ord[w.row] = w.value[7:0];
      asw_pkg::ModeStart: begin
        e_now = 0;
        e_best = 0;
        best_ord = cur_ord;
        temp_q = start_temp;
      end
      asw_pkg::ModeStep: begin
        if (w.row < n && w.col < n) begin
          base = near_len(w.row, w.col, n);
          t = cur_ord[w.row];
          cur_ord[w.row] = cur_ord[w.col];
          cur_ord[w.col] = t;
          chg = clamp(near_len(w.row, w.col, n) - base, asw_pkg::DeltaSat);
          if (chg <= 0 ||
              (longint'(temp_q) * neg_ln(w.draw)) >= (longint'(chg) << 24)) begin
            r.acc = 1'b1;
            e_now = clamp(e_now + chg, asw_pkg::EnergySat);
            if (e_now < e_best) begin
              e_best = e_now;
              best_ord = cur_ord;
              r.imp = 1'b1;
            end
          end else begin
            t = cur_ord[w.row];
            cur_ord[w.row] = cur_ord[w.col];
            cur_ord[w.col] = t;
          end
        end
        temp_q = 32'((longint'(temp_q) * cool) >> 16);
      end
      asw_pkg::ModeReadBest: r.best = best_ord[w.row];
      default: ;
    endcase
    r.chg = chg[18:0];
    r.energy = e_now[24:0];
    return r;
  endfunction

  task automatic offer(input in_word_t w, input bit typed, input out_word_t res);
    out_word_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= w.mode;
    row_i      <= w.row;
    col_i      <= w.col;
    value_i    <= w.value;
    draw_i     <= w.draw;
    do @(posedge clk_i); while (in_stall_o);
    p = anneal_word(w);
    pending_q.push_back(typed ? res : p);
  endtask

  task automatic send(input in_word_t w);
    offer(w, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input asw_pkg::cfg_idx_t idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      asw_pkg::CfgItemCount: item_cnt = data[8:0];
      asw_pkg::CfgStartTemp: start_temp = data;
      asw_pkg::CfgCooling:   cool = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic in_word_t mk(asw_pkg::mode_t m, int r, int c, int v, int d);
    in_word_t w;
    w.mode = m;
    w.row = r[7:0];
    w.col = c[7:0];
    w.value = v[15:0];
    w.draw = d[15:0];
    return w;
  endfunction

  function automatic in_word_t rand_word();
    int n, sel, r, c;
    n = (item_cnt > asw_pkg::MaxItemsDef) ? int'(asw_pkg::MaxItemsDef) : int'(item_cnt);
    if (n == 0) n = 1;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      r = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
      c = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
      return mk(asw_pkg::ModeStep, r, c, $urandom, $urandom_range(1, 65535));
    end
    if (sel < 70)
      return mk(asw_pkg::ModeReadBest, $urandom_range(0, 255), $urandom, $urandom, $urandom);
    if (sel < 78)
      return mk(asw_pkg::ModeLoadOrder, $urandom_range(0, 255), $urandom,
                int'({8'($urandom_range(0, 255)), pool[$urandom_range(0, PoolSize - 1)]}),
                $urandom);
    if (sel < 86)
      return mk(asw_pkg::ModeLoadDist, pool[$urandom_range(0, PoolSize - 1)],
                pool[$urandom_range(0, PoolSize - 1)], $urandom_range(0, 65535), $urandom);
    if (sel < 90) return mk(asw_pkg::ModeLoadDist, $urandom, $urandom, $urandom, $urandom);
    if (sel < 95) return mk(asw_pkg::ModeStart, $urandom, $urandom, $urandom, $urandom);
    return mk(asw_pkg::mode_t'($urandom_range(ModeUnusedLo, ModeUnusedHi)), $urandom,
              $urandom, $urandom, $urandom);
  endfunction

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word");
      end else begin
        e = pending_q.pop_front();
        if (accepted_o !== e.acc || improved_o !== e.imp || energy_change_o !== e.chg ||
            relative_energy_o !== e.energy || best_entry_o !== e.best) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     e.acc, e.imp, e.chg, e.energy, e.best, accepted_o, improved_o,
                     energy_change_o, relative_energy_o, best_entry_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int cfg_n [7];
    logic [31:0] cfg_t [7];
    logic [15:0] cfg_c [7];
    temp_q = asw_pkg::StartTempRst;
    e_now = 0;
    e_best = 0;
    cfg_n = '{256, 8, 2, 1, 511, 12, 0};
    cfg_t = '{asw_pkg::StartTempRst, 32'd1, 32'hFFFF_FFFF, $urandom, $urandom, 32'd655360,
              $urandom};
    cfg_c = '{asw_pkg::CoolingRst, 16'd1, 16'hFFFF, 16'($urandom), 16'($urandom), 16'd60000,
              16'($urandom)};
    cfg_n[6] = $urandom_range(3, 40);

    dir_tab[0]  = '{mk(asw_pkg::ModeLoadDist, 0, 255, 65535, 1), 1'b1, '0};
    dir_tab[1]  = '{mk(asw_pkg::ModeLoadDist, 255, 0, 0, 65535), 1'b1, '0};
    dir_tab[2]  = '{mk(asw_pkg::ModeLoadOrder, 255, 0, 16'hFFFF, 1), 1'b1, '0};
    dir_tab[3]  = '{mk(ModeUnusedLo, 255, 255, 65535, 65535), 1'b1, '0};
    dir_tab[4]  = '{mk(ModeUnusedHi, 0, 0, 0, 1), 1'b1, '0};
    dir_tab[5]  = '{mk(asw_pkg::ModeStep, 10, 10, 0, 1), 1'b1, '{1'b1, 1'b0, '0, '0, '0}};
    dir_tab[6]  = '{mk(asw_pkg::ModeStart, 0, 0, 0, 1), 1'b1, '0};
    dir_tab[7]  = '{mk(asw_pkg::ModeReadBest, 0, 0, 0, 1), 1'b0, '0};
    dir_tab[8]  = '{mk(asw_pkg::ModeReadBest, 255, 0, 0, 1), 1'b1,
                    '{1'b0, 1'b0, '0, '0, 8'd255}};
    dir_tab[9]  = '{mk(asw_pkg::ModeStep, 0, 1, 0, 65535), 1'b0, '0};
    dir_tab[10] = '{mk(asw_pkg::ModeStep, 1, 0, 0, 1), 1'b0, '0};
    dir_tab[11] = '{mk(asw_pkg::ModeStep, 0, 255, 0, 65535), 1'b0, '0};
    dir_tab[12] = '{mk(asw_pkg::ModeStep, 255, 254, 0, 1), 1'b0, '0};
    dir_tab[13] = '{mk(asw_pkg::ModeStep, 5, 9, 0, 32768), 1'b0, '0};
    dir_tab[14] = '{mk(asw_pkg::ModeStep, 254, 3, 0, 65535), 1'b0, '0};
    dir_tab[15] = '{mk(asw_pkg::ModeReadBest, 1, 0, 0, 1), 1'b0, '0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int a = 0; a < PoolSize; a++)
      for (int b = 0; b < PoolSize; b++)
        send(mk(asw_pkg::ModeLoadDist, pool[a], pool[b], $urandom_range(0, 65535), 1));
    for (int p = 0; p < 256; p++)
      send(mk(asw_pkg::ModeLoadOrder, p, 0,
              int'({8'($urandom_range(0, 255)), pool[$urandom_range(0, PoolSize - 1)]}), 1));
    foreach (dir_tab[k]) offer(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].res);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(asw_pkg::CfgItemCount, cfg_n[ph]);
      write_reg(asw_pkg::CfgStartTemp, cfg_t[ph]);
      write_reg(asw_pkg::CfgCooling, 32'(cfg_c[ph]));
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      gap_max = (ph % 2 == 0) ? 0 : $urandom_range(2, 8);
      send(mk(asw_pkg::ModeStart, 0, 0, 0, 1));
      for (int k = 0; k < PhaseWords; k++) begin
        if (ph == 1 && k == 10) hold_req = 1;
        send(rand_word());
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
